// ===== rtl/dbpwm_pkg.sv =====
`default_nettype none

package dbpwm_pkg;

    typedef logic [7:0] t_byte;

    // Item kinds on the input channel
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    // Configuration register indexes
    typedef logic [7:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TARGET_LEVEL = 8'd0;
    localparam t_cfg_idx CFG_DEAD_BAND    = 8'd1;

    localparam t_byte TARGET_LEVEL_RESET = 8'd128;
    localparam t_byte DEAD_BAND_RESET    = 8'd8;
    localparam t_byte DUTY_MIN           = 8'd0;
    localparam t_byte DUTY_MAX           = 8'd255;

    typedef struct packed {
        t_byte target_level;
        t_byte dead_band;
    } t_cfg;

    typedef struct packed {
        t_op   op;
        t_byte sample;
    } t_item;

    // Averager status for the item in flight
    typedef struct packed {
        logic  done;
        t_byte average;
    } t_avg_status;

    typedef struct packed {
        logic  pwm_level;
        t_byte duty;
        logic  average_ready;
        t_byte average;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/dbpwm_in_if.sv =====
`default_nettype none

interface dbpwm_in_if;
    import dbpwm_pkg::*;

    logic  valid;
    logic  ready;
    logic  op;
    t_byte sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/dbpwm_res_if.sv =====
`default_nettype none

interface dbpwm_res_if;
    import dbpwm_pkg::*;

    logic  valid;
    logic  ready;
    logic  pwm_level;
    t_byte duty;
    logic  average_ready;
    t_byte average;

    modport source (output valid, output pwm_level, output duty, output average_ready,
                    output average, input ready);
    modport sink   (input valid, input pwm_level, input duty, input average_ready,
                    input average, output ready);
endinterface

`default_nettype wire

// ===== rtl/dbpwm_cfg_if.sv =====
`default_nettype none

interface dbpwm_cfg_if;
    import dbpwm_pkg::*;

    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_byte    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dbpwm_avg.sv =====
`default_nettype none

module dbpwm_avg #(
    parameter int AVG_SAMPLES = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  dbpwm_pkg::t_op         i_op,
    input  dbpwm_pkg::t_byte       i_sample,
    output dbpwm_pkg::t_avg_status o_avg
);
    import dbpwm_pkg::*;

    localparam int SUM_W   = $clog2(255 * AVG_SAMPLES + 1);
    localparam int CNT_W   = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
    // Divide by reciprocal: floor(x / N) = (x * ceil(2^K / N)) >> K for x < 2^SUM_W
    localparam int DIV_SH  = SUM_W + CNT_W;
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SH) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_SAMPLES - 1);

    logic [SUM_W-1:0]  r_sum,   n_sum;
    logic [CNT_W-1:0]  r_count, n_count;
    t_byte             r_avg,   n_avg;
    logic [SUM_W-1:0]  w_sum_add;
    logic [PROD_W-1:0] w_prod;
    logic              w_done;

    // Sum including the sample in flight, and its scaled quotient
    assign w_sum_add = r_sum + {{(SUM_W-8){1'b0}}, i_sample};
    assign w_prod    = PROD_W'(w_sum_add) * PROD_W'(RECIP);

    // Advance the running sum; close a window on its last sample
    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        n_avg   = r_avg;
        w_done  = 1'b0;
        if (i_fire && (i_op == OP_SAMPLE)) begin
            if (r_count == CNT_LAST) begin
                n_sum   = '0;
                n_count = '0;
                n_avg   = w_prod[DIV_SH +: 8];
                w_done  = 1'b1;
            end else begin
                n_sum   = w_sum_add;
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    assign o_avg.done    = w_done;
    assign o_avg.average = n_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_avg   <= '0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_avg   <= n_avg;
        end
    end

    // Window count never passes its last position
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_LAST)
        else $error("sample count beyond window");

endmodule

`default_nettype wire

// ===== rtl/dbpwm_pwm.sv =====
`default_nettype none

module dbpwm_pwm (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  dbpwm_pkg::t_op         i_op,
    input  dbpwm_pkg::t_avg_status i_avg,
    input  dbpwm_pkg::t_cfg        i_cfg,
    output dbpwm_pkg::t_byte       o_duty,
    output logic                   o_pwm_level
);
    import dbpwm_pkg::*;

    t_byte              r_duty, n_duty;
    t_byte              r_cnt,  n_cnt;
    logic               r_pwm,  n_pwm;
    logic signed [9:0]  w_value;
    logic signed [9:0]  w_upper;
    logic signed [9:0]  w_lower;

    // Dead zone bounds in 10-bit signed arithmetic
    assign w_value = $signed({2'b00, i_avg.average});
    assign w_upper = $signed({2'b00, i_cfg.target_level}) + $signed({2'b00, i_cfg.dead_band});
    assign w_lower = $signed({2'b00, i_cfg.target_level}) - $signed({2'b00, i_cfg.dead_band});

    // Step the duty on a fresh average; advance the PWM counter on a tick
    always_comb begin
        n_duty = r_duty;
        n_cnt  = r_cnt;
        n_pwm  = r_pwm;
        if (i_fire) begin
            case (i_op)
                OP_SAMPLE: begin
                    if (i_avg.done) begin
                        if (w_value > w_upper) begin
                            if (r_duty != DUTY_MIN) n_duty = r_duty - 8'd1;
                        end else if (w_value < w_lower) begin
                            if (r_duty != DUTY_MAX) n_duty = r_duty + 8'd1;
                        end
                    end
                end
                OP_TICK: begin
                    n_cnt = r_cnt + 8'd1;
                    n_pwm = (n_cnt < r_duty);
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase
        end
    end

    assign o_duty      = n_duty;
    assign o_pwm_level = n_pwm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= '0;
            r_cnt  <= '0;
            r_pwm  <= 1'b0;
        end else begin
            r_duty <= n_duty;
            r_cnt  <= n_cnt;
            r_pwm  <= n_pwm;
        end
    end

    // Duty moves by at most one step per cycle
    a_duty_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_duty == $past(r_duty)) || (r_duty == $past(r_duty) + 8'd1)
                           || (r_duty == $past(r_duty) - 8'd1))
        else $error("duty jumped by more than one step");

    // A sample never changes the PWM output level
    a_pwm_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_op == OP_SAMPLE)) |=> (r_pwm == $past(r_pwm)))
        else $error("PWM level changed on a sample");

endmodule

`default_nettype wire

// ===== rtl/deadband_step_pwm_regulator.sv =====
// Dead-band step regulator with PWM output.
// Input channel i_in carries items of two kinds: op 0 is a converted sample, op 1 is a
// PWM timer tick. Every item yields exactly one result on o_res: the PWM level, the duty,
// a flag marking the sample that closed an averaging window, and the latest average.
// Every AVG_SAMPLES samples the mean is compared with target_level +/- dead_band and the
// duty steps down above the band, up below it, saturating at 0 and 255.
// Configuration writes on i_cfg (index 0 target_level, 1 dead_band, others dropped) are
// always taken and are to be made while no item is in flight.
// An accepted item is registered in the input register, processed and registered in the
// result register that drives o_res. Throughput: one item per cycle while o_res.ready is
// high, set by combinational averager and duty updates between input and result registers.
// Stall: a result held by o_res.ready low keeps the result register; one more item waits
// in the input register, after which i_in.ready drops.
// Reset (synchronous, active low) clears both pipeline stages, all regulator state and
// restores target_level 128, dead_band 8.
`default_nettype none

module deadband_step_pwm_regulator #(
    parameter int AVG_SAMPLES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbpwm_in_if.sink    i_in,
    dbpwm_res_if.source o_res,
    dbpwm_cfg_if.sink   i_cfg
);
    import dbpwm_pkg::*;

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    t_cfg        r_cfg;
    logic        w_adv;
    t_avg_status w_avg;
    t_byte       w_duty;
    logic        w_pwm_level;

    // Move the held item into the result stage when that stage is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_level <= TARGET_LEVEL_RESET;
            r_cfg.dead_band    <= DEAD_BAND_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TARGET_LEVEL: r_cfg.target_level <= i_cfg.data;
                CFG_DEAD_BAND:    r_cfg.dead_band    <= i_cfg.data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.op     <= t_op'(i_in.op);
            r_in.sample <= i_in.sample;
        end
    end

    dbpwm_avg #(
        .AVG_SAMPLES (AVG_SAMPLES)
    ) u_avg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_adv),
        .i_op     (r_in.op),
        .i_sample (r_in.sample),
        .o_avg    (w_avg)
    );

    dbpwm_pwm u_pwm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_adv),
        .i_op        (r_in.op),
        .i_avg       (w_avg),
        .i_cfg       (r_cfg),
        .o_duty      (w_duty),
        .o_pwm_level (w_pwm_level)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.pwm_level     <= w_pwm_level;
            r_out.duty          <= w_duty;
            r_out.average_ready <= w_avg.done;
            r_out.average       <= w_avg.average;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.pwm_level     = r_out.pwm_level;
    assign o_res.duty          = r_out.duty;
    assign o_res.average_ready = r_out.average_ready;
    assign o_res.average       = r_out.average;

    // An accepted item is held in the input stage next cycle
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_in_valid)
        else $error("accepted item not captured");

    // A waiting item is not dropped while the result stage is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_res.ready) |=> (r_in_valid && r_out_valid))
        else $error("item lost during output stall");

    // Only an advancing item refills the result stage after it drains
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !w_adv) |=> !r_out_valid)
        else $error("result appeared without an item");

endmodule

`default_nettype wire
